[rtl/mqu_pkg.sv]
// Shared types, codes and move encoding helpers for the move queue with undo log.
`default_nettype none

package mqu_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam logic [7:0] FRAMES_RESET = 8'd16;

  // Configuration register indexes.
  localparam logic [0:0] REG_FRAMES = 1'b0;

  // Operation codes.
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_SOLVE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Status codes.
  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_DROP  = 2'd1;
  localparam logic [1:0] STAT_IDLE  = 2'd2;
  localparam logic [1:0] STAT_FRAME = 2'd3;

  // Stored turn codes.
  localparam logic [1:0] TURN_POS  = 2'd0;
  localparam logic [1:0] TURN_NEG  = 2'd1;
  localparam logic [1:0] TURN_HALF = 2'd2;

  // Packed move: turns code, layer bit (1 is +1), axis.
  typedef struct packed {
    logic [1:0] tcode;
    logic       lbit;
    logic [1:0] axis;
  } move_t;

  typedef struct packed {
    logic [1:0] op;
    move_t      mv;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] axis;
    logic [1:0] layer;
    logic [2:0] turns;
    logic [7:0] frames;
    logic       done;
  } res_t;

  function automatic move_t pack_move(input logic [1:0] axis, input logic [1:0] layer,
                                      input logic [2:0] turns);
    move_t m;
    m.axis = axis;
    m.lbit = ~layer[1];
    if (turns[2]) begin
      m.tcode = TURN_NEG;
    end else if (turns[1]) begin
      m.tcode = TURN_HALF;
    end else begin
      m.tcode = TURN_POS;
    end
    return m;
  endfunction

  function automatic move_t invert_move(input move_t m);
    move_t r;
    r = m;
    if (m.tcode == TURN_POS) begin
      r.tcode = TURN_NEG;
    end else if (m.tcode == TURN_NEG) begin
      r.tcode = TURN_POS;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/mqu_engine.sv]
// Sequencer, queue and history memories, and the shared ring index adder.
`default_nettype none

module mqu_engine import mqu_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int IDX_W = $clog2(QUEUE_DEPTH),
  parameter int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire cmd_t             cmd,
  input  wire logic [7:0]       frames_per_move,
  input  wire logic             take,
  output logic                  idle,
  output logic                  res_valid,
  output res_t                  res,
  output logic [CNT_W-1:0]      queue_level,
  output logic [CNT_W-1:0]      history_level
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_PUSH    = 3'd1;
  localparam logic [2:0] S_SOLVE_RD = 3'd2;
  localparam logic [2:0] S_SOLVE_WR = 3'd3;
  localparam logic [2:0] S_TICK    = 3'd4;
  localparam logic [2:0] S_TICK_LD = 3'd5;
  localparam logic [2:0] S_TICK_ADV = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W:0]   SUM_DEPTH = (CNT_W + 1)'(QUEUE_DEPTH);

  logic [2:0]       state;
  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] hcount;
  logic [CNT_W-1:0] idx;
  logic             animating;
  logic [7:0]       countdown;
  move_t            cur_move;
  move_t            mv;

  move_t            fifo_mem [QUEUE_DEPTH];
  move_t            hist_mem [QUEUE_DEPTH];
  move_t            rd_fifo;
  move_t            rd_hist;

  logic             full;
  logic [CNT_W-1:0] add_b;
  logic [CNT_W:0]   sum;
  logic [CNT_W:0]   sum_wrap;
  logic [IDX_W-1:0] ring_idx;
  logic [CNT_W-1:0] idx_dec;
  logic             fifo_we;
  move_t            fifo_wdata;
  logic             hist_we;
  logic [7:0]       cd_next;
  logic [7:0]       cd_load;

  assign full = (count == CNT_FULL);
  assign idx_dec = idx - CNT_ONE;
  assign cd_next = countdown - 8'd1;
  assign cd_load = (frames_per_move == 8'd0) ? 8'd1 : frames_per_move;

  // The one ring adder: tail slot for writes, and head advance on a pop.
  assign add_b = (state == S_TICK_LD) ? CNT_ONE : count;
  assign sum = {{(CNT_W + 1 - IDX_W){1'b0}}, head} + {1'b0, add_b};
  assign sum_wrap = (sum >= SUM_DEPTH) ? (sum - SUM_DEPTH) : sum;
  assign ring_idx = sum_wrap[IDX_W-1:0];

  assign fifo_we = ((state == S_PUSH) || (state == S_SOLVE_WR)) && !full;
  assign fifo_wdata = (state == S_PUSH) ? mv : invert_move(rd_hist);
  assign hist_we = (state == S_PUSH) && !full && (hcount != CNT_FULL);

  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[ring_idx] <= fifo_wdata;
    end
    if (hist_we) begin
      hist_mem[hcount[IDX_W-1:0]] <= mv;
    end
    rd_fifo <= fifo_mem[head];
    rd_hist <= hist_mem[idx_dec[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head <= '0;
      count <= '0;
      hcount <= '0;
      idx <= '0;
      animating <= 1'b0;
      countdown <= '0;
      cur_move <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            mv <= cmd.mv;
            idx <= hcount;
            res <= '0;
            case (cmd.op)
              OP_PUSH:  state <= S_PUSH;
              OP_SOLVE: state <= S_SOLVE_RD;
              OP_TICK:  state <= S_TICK;
              default:  state <= S_DONE;
            endcase
          end
        end
        S_PUSH: begin
          if (full) begin
            res.status <= STAT_DROP;
          end else begin
            count <= count + CNT_ONE;
            if (hist_we) begin
              hcount <= hcount + CNT_ONE;
            end
          end
          state <= S_DONE;
        end
        S_SOLVE_RD: begin
          if (idx == '0) begin
            hcount <= '0;
            state <= S_DONE;
          end else begin
            idx <= idx_dec;
            state <= S_SOLVE_WR;
          end
        end
        S_SOLVE_WR: begin
          if (!full) begin
            count <= count + CNT_ONE;
          end
          state <= S_SOLVE_RD;
        end
        S_TICK: begin
          if (!animating && (count == '0)) begin
            res.status <= STAT_IDLE;
            state <= S_DONE;
          end else if (!animating) begin
            state <= S_TICK_LD;
          end else begin
            state <= S_TICK_ADV;
          end
        end
        S_TICK_LD: begin
          cur_move <= rd_fifo;
          head <= ring_idx;
          count <= count - CNT_ONE;
          countdown <= cd_load;
          animating <= 1'b1;
          state <= S_TICK_ADV;
        end
        S_TICK_ADV: begin
          countdown <= cd_next;
          if (cd_next == 8'd0) begin
            animating <= 1'b0;
          end
          res.status <= STAT_FRAME;
          res.axis <= cur_move.axis;
          res.layer <= cur_move.lbit ? 2'b01 : 2'b11;
          res.turns <= (cur_move.tcode == TURN_NEG) ? 3'b111 :
                       (cur_move.tcode == TURN_HALF) ? 3'b010 : 3'b001;
          res.frames <= cd_next;
          res.done <= (cd_next == 8'd0);
          state <= S_DONE;
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign idle = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign queue_level = count;
  assign history_level = hcount;

endmodule

`default_nettype wire

[rtl/move_queue_with_undo_log_top.sv]
// Top level: item handshakes, result register and the configuration register port.
`default_nettype none

// Move queue with undo log. A push item queues one cube move and records it in the
// history; a solve item walks the history newest first and queues each inverse; a tick
// item pops the next move into the animator or advances it by one frame. Every item
// returns exactly one result. in_ready is high only while the sequencer is idle, so
// items are taken one at a time. Between accepting an item and loading its result into
// the output register, the sequencer passes through these states, then S_DONE:
//   - a push: S_PUSH;
//   - a tick: S_TICK, plus S_TICK_LD to take a new move and S_TICK_ADV to advance one;
//   - a solve: S_SOLVE_RD, then S_SOLVE_WR and S_SOLVE_RD for each history entry;
//   - an unused operation: none.
// These steps are paced by the single ring index adder and by the registered reads of
// the queue and history memories. The next item can be accepted in the cycle after the
// result is loaded. A finished result waits in the output register, and the next item
// is accepted while it waits. If the output register is still full, the sequencer
// holds its result until the register frees up.
// frames_per_move sits at byte address 0 (reset value 16; zero acts as one frame) and
// must only be written while the block is idle.
module move_queue_with_undo_log_top import mqu_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int LEVEL_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         operation,
  input  wire logic [1:0]         in_axis,
  input  wire logic signed [1:0]  in_layer,
  input  wire logic signed [2:0]  in_turns,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              status,
  output logic [1:0]              cur_axis,
  output logic signed [1:0]       cur_layer,
  output logic signed [2:0]       cur_turns,
  output logic [7:0]              frames_remaining,
  output logic                    move_done,
  output logic [LEVEL_W-1:0]      queue_level,
  output logic [LEVEL_W-1:0]      history_level,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic               frames_per_move;
  logic [7:0]         frames_reg;
  logic               eng_idle;
  logic               eng_valid;
  res_t               eng_res;
  cmd_t               cmd;
  logic               load;
  logic [LEVEL_W-1:0] eng_qlevel;
  logic [LEVEL_W-1:0] eng_hlevel;
  logic [0:0]         reg_index;

  assign reg_index = paddr[2];
  assign pready = 1'b1;
  assign frames_per_move = (reg_index == REG_FRAMES);
  assign prdata = frames_per_move ? {24'd0, frames_reg} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_reg <= FRAMES_RESET;
    end else if (psel && penable && pwrite && pready && frames_per_move) begin
      frames_reg <= pwdata[7:0];
    end
  end

  assign in_ready = eng_idle;
  assign cmd.op = operation;
  assign cmd.mv = pack_move(in_axis, in_layer, in_turns);

  // The result register frees up when empty or when its item is being taken.
  assign load = eng_valid && (!out_valid || out_ready);

  mqu_engine #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .IDX_W($clog2(QUEUE_DEPTH)),
    .CNT_W(LEVEL_W)
  ) u_engine (
    .clk(clk),
    .rst(rst),
    .start(in_valid && in_ready),
    .cmd(cmd),
    .frames_per_move(frames_reg),
    .take(load),
    .idle(eng_idle),
    .res_valid(eng_valid),
    .res(eng_res),
    .queue_level(eng_qlevel),
    .history_level(eng_hlevel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status <= eng_res.status;
      cur_axis <= eng_res.axis;
      cur_layer <= eng_res.layer;
      cur_turns <= eng_res.turns;
      frames_remaining <= eng_res.frames;
      move_done <= eng_res.done;
      queue_level <= eng_qlevel;
      history_level <= eng_hlevel;
    end
  end

endmodule

`default_nettype wire
